// ===== sv/dts_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dts_pkg
// Shared constants and codes for the depth-first topological sort unit.
// ----------------------------------------------------------------------------
package dts_pkg;
    localparam int MAX_NODES_DEF = 64;
    localparam int MAX_EDGES_DEF = 256;

    localparam logic [1:0] ACT_ADD_NODE = 2'd0;
    localparam logic [1:0] ACT_ADD_EDGE = 2'd1;
    localparam logic [1:0] ACT_RUN      = 2'd2;
    localparam logic [1:0] ACT_CLEAR    = 2'd3;

    localparam logic [1:0] KIND_NODE  = 2'd0;
    localparam logic [1:0] KIND_CYCLE = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    localparam logic [1:0] COL_WHITE = 2'd0;
    localparam logic [1:0] COL_GRAY  = 2'd1;
    localparam logic [1:0] COL_BLACK = 2'd2;
endpackage
`default_nettype wire

// ===== sv/dts_out_reg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dts_out_reg
// Two-entry skid buffer for result items.
// ----------------------------------------------------------------------------
module dts_out_reg
    import dts_pkg::*;
#(
    parameter int W = 10
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_stall,
    input  wire logic [W-1:0] i_data,
    output logic              o_valid,
    input  wire logic         i_stall,
    output logic [W-1:0]      o_data
);
    logic         r_v0, r_v1;
    logic [W-1:0] r_d0, r_d1;

    assign o_valid = r_v0;
    assign o_data  = r_d0;
    assign o_stall = r_v1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            if (!r_v0 || !i_stall) begin
                if (r_v1) begin
                    r_v0 <= 1'b1;
                    r_d0 <= r_d1;
                    r_v1 <= 1'b0;
                end else begin
                    r_v0 <= i_valid;
                    r_d0 <= i_data;
                end
            end else if (i_valid && !r_v1) begin
                r_v1 <= 1'b1;
                r_d1 <= i_data;
            end
        end
    end
endmodule
`default_nettype wire

// ===== sv/dfs_topological_sort_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dfs_topological_sort_unit
// Loads a directed graph and emits a depth-first topological order.
// ----------------------------------------------------------------------------
// Add node is done in the idle state; add edge also goes through S_EDGE. Clear
// and run first sweep the per-node tables, one node per cycle. A run then
// checks each root id in S_ROOT and S_RWAIT, follows every edge through S_TOP,
// S_TOPW, S_EDGW, S_SINK, S_SINKW and S_SCHK, finishes every node in S_TOP and
// S_TOPW, and drains the finish list through S_EMIT and S_EMITW per result,
// held by any output stalls. Results are registered in a two-entry output
// buffer. After reset the node tables are swept before the first item is taken.
module dfs_topological_sort_unit
    import dts_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int MAX_EDGES = MAX_EDGES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [1:0] i_action,
    input  wire logic [5:0] i_node_a,
    input  wire logic [5:0] i_node_b,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [5:0]      o_node_id,
    output logic [1:0]      o_kind,
    output logic            o_overflowed,
    output logic            o_last
);
    localparam int NW = $clog2(MAX_NODES);
    localparam int EW = $clog2(MAX_EDGES + 1);
    localparam int EA = $clog2(MAX_EDGES);
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam logic [EW-1:0] NONE = EW'(MAX_EDGES);

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_EDGE  = 4'd2;
    localparam logic [3:0] S_ROOT  = 4'd3;
    localparam logic [3:0] S_RWAIT = 4'd4;
    localparam logic [3:0] S_TOP   = 4'd5;
    localparam logic [3:0] S_TOPW  = 4'd6;
    localparam logic [3:0] S_EDGW  = 4'd7;
    localparam logic [3:0] S_SINK  = 4'd8;
    localparam logic [3:0] S_SINKW = 4'd9;
    localparam logic [3:0] S_EMIT  = 4'd10;
    localparam logic [3:0] S_EMITW = 4'd11;
    localparam logic [3:0] S_ONE   = 4'd12;
    localparam logic [3:0] S_SCHK  = 4'd13;

    // Node table: present, color, first and last edge.
    logic            m_pres [MAX_NODES];
    logic [1:0]      m_col  [MAX_NODES];
    logic [EW-1:0]   m_first[MAX_NODES];
    logic [EW-1:0]   m_last [MAX_NODES];
    logic [5:0]      m_sink [MAX_EDGES];
    logic [EW-1:0]   m_next [MAX_EDGES];
    logic [NW-1:0]   m_wnode[MAX_NODES];
    logic [EW-1:0]   m_wcur [MAX_NODES];
    logic [NW-1:0]   m_fin  [MAX_NODES];

    logic [3:0]    r_st;
    logic          r_clr_run;
    logic [NW:0]   r_cnt;
    logic [EW-1:0] r_ecount;
    logic          r_ovf;
    logic [NW-1:0] r_a, r_b, r_node;
    logic [EW-1:0] r_cur;
    logic [CW-1:0] r_depth, r_fcnt;
    logic          r_any;
    logic [1:0]    r_okind;

    // Registered read data.
    logic          q_pres;
    logic [1:0]    q_col;
    logic [EW-1:0] q_first, q_last;
    logic [5:0]    q_sink;
    logic [EW-1:0] q_next;
    logic [NW-1:0] q_wnode, q_fin;
    logic [EW-1:0] q_wcur;

    logic [NW-1:0] n_naddr;
    logic          ob_valid, ob_stall;
    logic [9:0]    ob_data;

    logic [5:0]    a6, b6;
    assign a6 = i_node_a;
    assign b6 = i_node_b;
    logic a_ok, b_ok;
    assign a_ok = 32'(a6) < MAX_NODES;
    assign b_ok = 32'(b6) < MAX_NODES;

    assign o_stall = (r_st != S_IDLE);

    logic          acc;
    assign acc = i_valid && (r_st == S_IDLE);

    logic [NW-1:0] top;
    assign top = NW'(r_depth - CW'(1));

    always_ff @(posedge i_clk) begin
        q_pres  <= m_pres[n_naddr];
        q_col   <= m_col[n_naddr];
        q_first <= m_first[n_naddr];
        q_last  <= m_last[n_naddr];
        q_sink  <= m_sink[r_cur[EA-1:0]];
        q_next  <= m_next[r_cur[EA-1:0]];
        q_wnode <= m_wnode[top];
        q_wcur  <= m_wcur[top];
        q_fin   <= m_fin[NW'(r_fcnt - CW'(1))];
    end

    always_comb begin
        n_naddr = r_node;
        if (r_st == S_IDLE) n_naddr = NW'(a6);
        else if (r_st == S_SINKW) n_naddr = r_b;
    end

    assign ob_valid = (r_st == S_EMITW || r_st == S_ONE);
    always_comb begin
        if (r_st == S_ONE)
            ob_data = {6'd0, r_okind, r_ovf, 1'b1};
        else
            ob_data = {6'(q_fin), KIND_NODE, r_ovf, (r_fcnt == CW'(1))};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= S_INIT;
            r_clr_run <= 1'b0;
            r_cnt     <= '0;
            r_ecount  <= '0;
            r_ovf     <= 1'b0;
        end else begin
            case (r_st)
                S_INIT: begin
                    if (r_clr_run) m_col[r_cnt[NW-1:0]] <= COL_WHITE;
                    else begin
                        m_pres[r_cnt[NW-1:0]]  <= 1'b0;
                        m_first[r_cnt[NW-1:0]] <= NONE;
                        m_last[r_cnt[NW-1:0]]  <= NONE;
                    end
                    if (32'(r_cnt) == MAX_NODES - 1) begin
                        r_cnt <= '0;
                        if (r_clr_run) begin
                            r_st   <= S_ROOT;
                            r_node <= '0;
                            r_fcnt <= '0;
                            r_any  <= 1'b0;
                        end else r_st <= S_IDLE;
                    end else r_cnt <= r_cnt + (NW+1)'(1);
                end
                S_IDLE: begin
                    if (acc) begin
                        case (i_action)
                            ACT_ADD_NODE: if (a_ok) m_pres[NW'(a6)] <= 1'b1;
                            ACT_ADD_EDGE: if (a_ok && b_ok) begin
                                m_pres[NW'(a6)] <= 1'b1;
                                if (r_ecount != NONE) m_next[r_ecount[EA-1:0]] <= NONE;
                                r_a <= NW'(a6);
                                r_b <= NW'(b6);
                                r_node <= NW'(a6);
                                r_st <= S_EDGE;
                            end
                            ACT_RUN: begin
                                r_clr_run <= 1'b1;
                                r_cnt <= '0;
                                r_st <= S_INIT;
                            end
                            default: begin
                                r_clr_run <= 1'b0;
                                r_cnt <= '0;
                                r_ecount <= '0;
                                r_ovf <= 1'b0;
                                r_st <= S_INIT;
                            end
                        endcase
                    end
                end
                S_EDGE: begin
                    // q_first/q_last hold the source's list ends.
                    m_pres[r_b] <= 1'b1;
                    if (r_ecount == NONE) r_ovf <= 1'b1;
                    else begin
                        m_sink[r_ecount[EA-1:0]] <= 6'(r_b);
                        if (q_last != NONE) m_next[q_last[EA-1:0]] <= r_ecount;
                        else m_first[r_a] <= r_ecount;
                        m_last[r_a] <= r_ecount;
                        r_ecount <= r_ecount + EW'(1);
                    end
                    r_st <= S_IDLE;
                end
                S_ROOT: r_st <= S_RWAIT;
                S_RWAIT: begin
                    if (q_pres) r_any <= 1'b1;
                    if (q_pres && q_col == COL_WHITE) begin
                        m_col[r_node]   <= COL_GRAY;
                        m_wnode[0]      <= r_node;
                        m_wcur[0]       <= q_first;
                        r_depth         <= CW'(1);
                        r_st            <= S_TOP;
                    end else if (32'(r_node) == MAX_NODES - 1) begin
                        r_st <= (r_fcnt == '0) ? S_ONE : S_EMIT;
                        r_okind <= KIND_EMPTY;
                    end else begin
                        r_node <= r_node + NW'(1);
                        r_st <= S_ROOT;
                    end
                end
                S_TOP: r_st <= S_TOPW;
                S_TOPW: begin
                    r_cur <= q_wcur;
                    if (q_wcur != NONE && q_wcur < r_ecount) r_st <= S_EDGW;
                    else begin
                        m_col[q_wnode] <= COL_BLACK;
                        m_fin[NW'(r_fcnt)] <= q_wnode;
                        r_fcnt <= r_fcnt + CW'(1);
                        r_depth <= r_depth - CW'(1);
                        if (r_depth == CW'(1)) begin
                            if (32'(r_node) == MAX_NODES - 1) begin
                                r_st <= S_EMIT;
                            end else begin
                                r_node <= r_node + NW'(1);
                                r_st <= S_ROOT;
                            end
                        end else r_st <= S_TOP;
                    end
                end
                S_EDGW: r_st <= S_SINK;
                S_SINK: begin
                    m_wcur[top] <= q_next;
                    if (32'(q_sink) >= MAX_NODES) r_st <= S_TOP;
                    else begin
                        r_b <= NW'(q_sink);
                        r_st <= S_SINKW;
                    end
                end
                S_SINKW: r_st <= S_SCHK;
                S_SCHK: begin
                    // Sink color and first edge are available.
                    if (q_col == COL_GRAY) begin
                        r_okind <= KIND_CYCLE;
                        r_st <= S_ONE;
                    end else if (q_col == COL_WHITE && 32'(r_depth) < MAX_NODES) begin
                        m_col[r_b] <= COL_GRAY;
                        m_wnode[NW'(r_depth)] <= r_b;
                        m_wcur[NW'(r_depth)] <= q_first;
                        r_depth <= r_depth + CW'(1);
                        r_st <= S_TOP;
                    end else r_st <= S_TOP;
                end
                S_ONE: begin
                    if (!ob_stall) r_st <= S_IDLE;
                end
                S_EMIT: r_st <= S_EMITW;
                S_EMITW: begin
                    if (!ob_stall) begin
                        r_fcnt <= r_fcnt - CW'(1);
                        r_st <= (r_fcnt == CW'(1)) ? S_IDLE : S_EMIT;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    dts_out_reg #(.W(10)) u_out (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(ob_valid), .o_stall(ob_stall), .i_data(ob_data),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_data({o_node_id, o_kind, o_overflowed, o_last})
    );
endmodule
`default_nettype wire
